/* src/v3alu_pkg.sv */
package v3alu_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // Exact sums of three products need two guard bits above a full product.
   localparam int SUM_BITS  = 2 * WORD_BITS + 2;
   localparam int LANE_BITS = 2 * WORD_BITS + 2;
   localparam int DIVN_BITS = WORD_BITS + FRAC_BITS;
   localparam int ROOT_STEPS = WORD_BITS;
   localparam int STAGES = 2 + ROOT_STEPS + DIVN_BITS;

   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_DIV   = 4'd3;
   localparam logic [3:0] OP_DOT   = 4'd4;
   localparam logic [3:0] OP_LEN   = 4'd5;
   localparam logic [3:0] OP_ROOT  = 4'd6;
   localparam logic [3:0] OP_NORM  = 4'd7;
   localparam logic [3:0] OP_SQLEN = 4'd8;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DIVZERO = 2'd1;
   localparam logic [1:0] ST_NEGROOT = 2'd2;
   localparam logic [1:0] ST_OVF     = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

endpackage

/* src/v3alu_chan.sv */
interface v3alu_req_if;
   logic                 valid;
   logic                 ready;
   logic [3:0]           operation;
   v3alu_pkg::word_type  a_x;
   v3alu_pkg::word_type  a_y;
   v3alu_pkg::word_type  a_z;
   v3alu_pkg::word_type  b_x;
   v3alu_pkg::word_type  b_y;
   v3alu_pkg::word_type  b_z;
   v3alu_pkg::word_type  scalar_in;
   logic                 use_scalar;

   modport source (output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                   use_scalar, input ready);
   modport sink (input valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                 use_scalar, output ready);
endinterface

interface v3alu_rsp_if;
   logic                 valid;
   logic                 ready;
   v3alu_pkg::word_type  res_x;
   v3alu_pkg::word_type  res_y;
   v3alu_pkg::word_type  res_z;
   v3alu_pkg::word_type  res_scalar;
   logic [1:0]           status;

   modport source (output valid, res_x, res_y, res_z, res_scalar, status, input ready);
   modport sink (input valid, res_x, res_y, res_z, res_scalar, status, output ready);
endinterface

/* src/vector3_alu_with_normalize.sv */
// Channel   Direction  Contents
// req_chan  in         operation, vectors a and b, scalar_in, use_scalar
// rsp_chan  out        res_x, res_y, res_z, res_scalar, status
//
// One item enters per cycle while the output is not stalled. The pipeline
// has one multiply stage, one summing stage, one stage per root bit (32 at
// 32.16) and one stage per quotient bit (48) for all three lanes, then the
// output register. Reset is synchronous and clears only the valid bits.
// When the output register holds an untaken result, the whole pipeline holds.
module vector3_alu_with_normalize (
   input logic clock,
   input logic reset,
   v3alu_req_if.sink req_chan,
   v3alu_rsp_if.source rsp_chan
);

   localparam int W   = v3alu_pkg::WORD_BITS;
   localparam int F   = v3alu_pkg::FRAC_BITS;
   localparam int SW  = v3alu_pkg::SUM_BITS;
   localparam int LW  = v3alu_pkg::LANE_BITS;
   localparam int DW  = v3alu_pkg::DIVN_BITS;
   localparam int RS  = v3alu_pkg::ROOT_STEPS;
   localparam int NST = v3alu_pkg::STAGES;

   typedef struct packed {
      logic [3:0]           op;
      logic [2:0][W-1:0]    a_v;
      logic [2:0][W-1:0]    b_v;
      logic [2:0][2*W-1:0]  prod;
      logic [2:0][LW-1:0]   lane;
      logic [LW-1:0]        scal;
      logic [2:0]           dz;
      logic [2:0]           dsign;
      logic [2:0]           nz;
      logic                 nroot;
      logic                 div_on;
      logic [2*W-1:0]       sq_s;
      logic [W:0]           sq_rem;
      logic [W-1:0]         sq_root;
      logic [2:0][DW-1:0]   dv_n;
      logic [2:0][DW-1:0]   dv_q;
      logic [2:0][W-1:0]    dv_rem;
      logic [2:0][W-1:0]    dv_d;
   } stage_type;

   typedef struct packed {
      logic [W-1:0] res_x;
      logic [W-1:0] res_y;
      logic [W-1:0] res_z;
      logic [W-1:0] res_scalar;
      logic [1:0]   status;
   } out_type;

   // Sum of products, lane and divider setup and the root operand.
   function automatic stage_type prep_fn(input stage_type x);
      stage_type              y;
      logic signed [SW-1:0]   dot;
      logic                   neg;
      logic [W-1:0]           num;
      logic [W-1:0]           nmag;
      logic [W-1:0]           dmag;
      y = x;
      dot = SW'($signed(x.prod[0])) + SW'($signed(x.prod[1])) + SW'($signed(x.prod[2]));
      neg = dot[SW-1];
      y.sq_rem = '0;
      y.sq_root = '0;
      if (x.op == v3alu_pkg::OP_LEN || x.op == v3alu_pkg::OP_NORM ||
          (x.op == v3alu_pkg::OP_ROOT && !neg)) begin
         y.sq_s = dot[2*W-1:0];
      end else begin
         y.sq_s = '0;
      end
      y.nroot = (x.op == v3alu_pkg::OP_ROOT) && neg;
      // The squared length is zero only for the zero vector, which passes through.
      y.div_on = (x.op == v3alu_pkg::OP_DIV) || (x.op == v3alu_pkg::OP_NORM && dot != '0);
      y.lane = '0;
      y.scal = '0;
      for (int i = 0; i < 3; i++) begin
         case (x.op)
            v3alu_pkg::OP_ADD: y.lane[i] = LW'($signed(x.a_v[i])) + LW'($signed(x.b_v[i]));
            v3alu_pkg::OP_SUB: y.lane[i] = LW'($signed(x.a_v[i])) - LW'($signed(x.b_v[i]));
            v3alu_pkg::OP_MUL: y.lane[i] = LW'($signed(x.prod[i]) >>> F);
            v3alu_pkg::OP_NORM: y.lane[i] = LW'($signed(x.b_v[i]));
            default: y.lane[i] = '0;
         endcase
         num = (x.op == v3alu_pkg::OP_NORM) ? x.b_v[i] : x.a_v[i];
         nmag = num[W-1] ? (~num + 1'b1) : num;
         dmag = x.b_v[i][W-1] ? (~x.b_v[i] + 1'b1) : x.b_v[i];
         y.dv_n[i] = {nmag, {F{1'b0}}};
         y.dv_d[i] = dmag;
         y.dv_rem[i] = '0;
         y.dv_q[i] = '0;
         y.nz[i] = (nmag != '0);
         y.dsign[i] = num[W-1] ^ ((x.op == v3alu_pkg::OP_DIV) & x.b_v[i][W-1]);
         y.dz[i] = (x.op == v3alu_pkg::OP_DIV) && (x.b_v[i] == '0);
      end
      if (x.op == v3alu_pkg::OP_DOT || x.op == v3alu_pkg::OP_SQLEN) begin
         y.scal = LW'(dot >>> F);
      end
      return y;
   endfunction

   // One restoring square-root digit: two operand bits in, one root bit out.
   function automatic stage_type root_step_fn(input stage_type x);
      stage_type    y;
      logic [W+2:0] rem2;
      logic [W+2:0] trial;
      y = x;
      rem2 = {x.sq_rem, x.sq_s[2*W-1 -: 2]};
      trial = {1'b0, x.sq_root, 2'b01};
      if (rem2 >= trial) begin
         y.sq_rem = rem2[W:0] - trial[W:0];
         y.sq_root = {x.sq_root[W-2:0], 1'b1};
      end else begin
         y.sq_rem = rem2[W:0];
         y.sq_root = {x.sq_root[W-2:0], 1'b0};
      end
      y.sq_s = {x.sq_s[2*W-3:0], 2'b00};
      return y;
   endfunction

   // The finished root becomes the scalar result or the normalize divisor.
   function automatic stage_type post_root_fn(input stage_type x);
      stage_type y;
      y = x;
      if (x.op == v3alu_pkg::OP_NORM) begin
         for (int i = 0; i < 3; i++) begin
            y.dv_d[i] = x.sq_root;
         end
      end
      if (x.op == v3alu_pkg::OP_LEN || (x.op == v3alu_pkg::OP_ROOT && !x.nroot)) begin
         y.scal = LW'(x.sq_root);
      end
      return y;
   endfunction

   // One restoring division bit for each of the three lanes.
   function automatic stage_type div_step_fn(input stage_type x);
      stage_type  y;
      logic [W:0] rem2;
      logic [W:0] dext;
      y = x;
      for (int i = 0; i < 3; i++) begin
         rem2 = {x.dv_rem[i], x.dv_n[i][DW-1]};
         dext = {1'b0, x.dv_d[i]};
         if (rem2 >= dext) begin
            y.dv_rem[i] = W'(rem2 - dext);
            y.dv_q[i] = {x.dv_q[i][DW-2:0], 1'b1};
         end else begin
            y.dv_rem[i] = rem2[W-1:0];
            y.dv_q[i] = {x.dv_q[i][DW-2:0], 1'b0};
         end
         y.dv_n[i] = {x.dv_n[i][DW-2:0], 1'b0};
      end
      return y;
   endfunction

   // Clamp to the word range; the top bit flags a clamp.
   function automatic logic [W:0] sat_fn(input logic [LW-1:0] v);
      logic signed [LW-1:0] vmax;
      logic signed [LW-1:0] vmin;
      vmax = LW'({1'b0, {(W-1){1'b1}}});
      vmin = LW'($signed({1'b1, {(W-1){1'b0}}}));
      if ($signed(v) > vmax) begin
         return {1'b1, vmax[W-1:0]};
      end else if ($signed(v) < vmin) begin
         return {1'b1, vmin[W-1:0]};
      end
      return {1'b0, v[W-1:0]};
   endfunction

   stage_type        pipe_ff [NST];
   stage_type        pipe_in [NST];
   logic [NST-1:0]   valid_ff;
   logic [NST-1:0]   valid_in;
   out_type          out_ff;
   out_type          out_in;
   logic             out_valid_ff;
   logic             adv;

   assign adv = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign valid_in = {valid_ff[NST-2:0], req_chan.valid};

   always_comb begin
      logic [2:0][W-1:0] av;
      logic [2:0][W-1:0] bv;
      logic [W-1:0]      mx;
      logic              bcast;
      logic              bsq;
      av = {req_chan.a_z, req_chan.a_y, req_chan.a_x};
      bv = {req_chan.b_z, req_chan.b_y, req_chan.b_x};
      bcast = req_chan.use_scalar && (req_chan.operation <= v3alu_pkg::OP_DIV);
      bsq = (req_chan.operation == v3alu_pkg::OP_LEN) ||
            (req_chan.operation == v3alu_pkg::OP_NORM) ||
            (req_chan.operation == v3alu_pkg::OP_SQLEN);
      pipe_in[0] = '0;
      pipe_in[0].op = req_chan.operation;
      pipe_in[0].a_v = av;
      for (int i = 0; i < 3; i++) begin
         pipe_in[0].b_v[i] = bcast ? req_chan.scalar_in : bv[i];
         mx = bsq ? bv[i] : av[i];
         pipe_in[0].prod[i] = $signed(mx) * $signed(pipe_in[0].b_v[i]);
      end
      pipe_in[1] = prep_fn(pipe_ff[0]);
      for (int k = 2; k < NST; k++) begin
         if (k < 2 + RS) begin
            pipe_in[k] = root_step_fn(pipe_ff[k-1]);
         end else if (k == 2 + RS) begin
            pipe_in[k] = div_step_fn(post_root_fn(pipe_ff[k-1]));
         end else begin
            pipe_in[k] = div_step_fn(pipe_ff[k-1]);
         end
      end
   end

   always_comb begin
      stage_type               x;
      logic [2:0][LW-1:0]      v;
      logic [2:0][W:0]         sv;
      logic [W:0]              ss;
      logic signed [LW-1:0]    vmax;
      logic signed [LW-1:0]    vmin;
      x = pipe_ff[NST-1];
      vmax = LW'({1'b0, {(W-1){1'b1}}});
      vmin = LW'($signed({1'b1, {(W-1){1'b0}}}));
      for (int i = 0; i < 3; i++) begin
         if (!x.div_on) begin
            v[i] = x.lane[i];
         end else if (x.dz[i]) begin
            v[i] = !x.nz[i] ? '0 : (x.dsign[i] ? vmin : vmax);
         end else if (x.dsign[i]) begin
            v[i] = LW'(0) - LW'(x.dv_q[i]);
         end else begin
            v[i] = LW'(x.dv_q[i]);
         end
         sv[i] = sat_fn(v[i]);
      end
      ss = sat_fn(x.scal);
      out_in.res_x = sv[0][W-1:0];
      out_in.res_y = sv[1][W-1:0];
      out_in.res_z = sv[2][W-1:0];
      out_in.res_scalar = ss[W-1:0];
      if (|x.dz) begin
         out_in.status = v3alu_pkg::ST_DIVZERO;
      end else if (x.nroot) begin
         out_in.status = v3alu_pkg::ST_NEGROOT;
      end else if (sv[0][W] || sv[1][W] || sv[2][W] || ss[W]) begin
         out_in.status = v3alu_pkg::ST_OVF;
      end else begin
         out_in.status = v3alu_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
         out_valid_ff <= valid_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.res_x = out_ff.res_x;
   assign rsp_chan.res_y = out_ff.res_y;
   assign rsp_chan.res_z = out_ff.res_z;
   assign rsp_chan.res_scalar = out_ff.res_scalar;
   assign rsp_chan.status = out_ff.status;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline valid bits moved during a stall");

   a_negroot_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status == v3alu_pkg::ST_NEGROOT |-> out_ff.res_scalar == '0)
      else $error("negative root operand with a nonzero scalar result");

   a_div_ops: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NST-1] && pipe_ff[NST-1].div_on |->
         pipe_ff[NST-1].op == v3alu_pkg::OP_DIV || pipe_ff[NST-1].op == v3alu_pkg::OP_NORM)
      else $error("divider result selected for an operation that does not divide");

   a_divzero_src: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NST-1] && (|pipe_ff[NST-1].dz) |-> pipe_ff[NST-1].op == v3alu_pkg::OP_DIV)
      else $error("divide by zero flagged outside the divide operation");

endmodule

/* tb/vector3_alu_with_normalize_tb.sv */
`timescale 1ns / 100ps

module vector3_alu_with_normalize_tb;

   localparam logic [3:0] OP_SPARE_LO = 4'd9;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;
   localparam int RANDOM_ITEMS = 1030;
   localparam int MAX_WAIT = 11;

   typedef struct {
      logic [3:0] op;
      v3alu_pkg::word_type   ax, ay, az;
      v3alu_pkg::word_type   bx, by, bz;
      v3alu_pkg::word_type   scalar;
      logic       use_scalar;
   } vec_req_type;

   typedef struct {
      v3alu_pkg::word_type   x, y, z, s;
      logic [1:0] st;
   } vec_rsp_type;

   typedef struct {
      vec_req_type req;
      bit       typed;
      vec_rsp_type exp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm = 1'b0;
   int   errors = 0;
   int   n_results = 0;
   int   op_count[16];
   int   status_count[4];
   int   stall_left = 0;
   vec_rsp_type  vector_results_q[$];
   stim_row_type stim_table[$];

   v3alu_req_if req_bus();
   v3alu_rsp_if rsp_bus();

   vector3_alu_with_normalize dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always #5 clock = ~clock;

   function automatic void raise_status(inout logic [1:0] st, input logic [1:0] code);
      if (st == v3alu_pkg::ST_OK || code < st) st = code;
   endfunction

   function automatic v3alu_pkg::word_type clamp_word(input logic signed [127:0] v,
                                                      inout logic [1:0] st);
      if (v > 128'sh7fffffff) begin
         raise_status(st, v3alu_pkg::ST_OVF);
         return 32'h7fffffff;
      end else if (v < -128'sh80000000) begin
         raise_status(st, v3alu_pkg::ST_OVF);
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [63:0] floor_root(input logic [127:0] s);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if ({64'd0, c} * {64'd0, c} <= s) r = c;
      end
      return r;
   endfunction

   // Quotient in Q16.16, truncated toward zero; a zero divisor saturates by sign.
   function automatic logic signed [127:0] fixed_quotient(input logic signed [127:0] n,
                                                          input logic signed [127:0] d,
                                                          inout logic [1:0] st);
      if (d == 0) begin
         raise_status(st, v3alu_pkg::ST_DIVZERO);
         if (n > 0) return 128'sh7fffffff;
         if (n < 0) return -128'sh80000000;
         return 0;
      end
      return (n <<< v3alu_pkg::FRAC_BITS) / d;
   endfunction

   function automatic vec_rsp_type vector_result(input vec_req_type r);
      logic signed [127:0] a[3], b[3], lane[3], sc, sum;
      logic [1:0] st;
      vec_rsp_type res;
      st = v3alu_pkg::ST_OK;
      a[0] = $signed(r.ax); a[1] = $signed(r.ay); a[2] = $signed(r.az);
      b[0] = $signed(r.bx); b[1] = $signed(r.by); b[2] = $signed(r.bz);
      for (int i = 0; i < 3; i++) lane[i] = 0;
      sc = 0;
      case (r.op)
         v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_MUL, v3alu_pkg::OP_DIV: begin
            for (int i = 0; i < 3; i++) begin
               sum = r.use_scalar ? $signed(r.scalar) : b[i];
               case (r.op)
                  v3alu_pkg::OP_ADD: lane[i] = a[i] + sum;
                  v3alu_pkg::OP_SUB: lane[i] = a[i] - sum;
                  v3alu_pkg::OP_MUL: lane[i] = (a[i] * sum) >>> v3alu_pkg::FRAC_BITS;
                  default: lane[i] = fixed_quotient(a[i], sum, st);
               endcase
            end
         end
         v3alu_pkg::OP_DOT:
            sc = (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> v3alu_pkg::FRAC_BITS;
         v3alu_pkg::OP_LEN:
            sc = $signed({64'd0, floor_root(b[0] * b[0] + b[1] * b[1] + b[2] * b[2])});
         v3alu_pkg::OP_ROOT: begin
            sum = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            if (sum < 0) raise_status(st, v3alu_pkg::ST_NEGROOT);
            else sc = $signed({64'd0, floor_root(sum)});
         end
         v3alu_pkg::OP_NORM: begin
            sum = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
            // A zero vector passes through untouched.
            if (sum == 0) begin
               for (int i = 0; i < 3; i++) lane[i] = b[i];
            end else begin
               sum = $signed({64'd0, floor_root(sum)});
               for (int i = 0; i < 3; i++) lane[i] = fixed_quotient(b[i], sum, st);
            end
         end
         v3alu_pkg::OP_SQLEN:
            sc = (b[0] * b[0] + b[1] * b[1] + b[2] * b[2]) >>> v3alu_pkg::FRAC_BITS;
         default: ;
      endcase
      res.x = clamp_word(lane[0], st);
      res.y = clamp_word(lane[1], st);
      res.z = clamp_word(lane[2], st);
      res.s = clamp_word(sc, st);
      res.st = st;
      return res;
   endfunction

   function automatic v3alu_pkg::word_type rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         3, 4: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
         5: return $urandom_range(0, 32'h3ffffff) - 32'h1ffffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic vec_req_type rand_request();
      vec_req_type r;
      r.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
      r.ax = rand_word(); r.ay = rand_word(); r.az = rand_word();
      r.bx = rand_word(); r.by = rand_word(); r.bz = rand_word();
      r.scalar = rand_word();
      r.use_scalar = 1'($urandom_range(0, 1));
      // Whole zero vectors exercise normalize pass-through and divide by zero.
      if ($urandom_range(0, 15) == 0) begin
         r.bx = '0; r.by = '0; r.bz = '0; r.scalar = '0;
      end
      return r;
   endfunction

   task automatic send_request(input vec_req_type r, input bit typed, input vec_rsp_type ex);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= r.op;
      req_bus.a_x        <= r.ax;
      req_bus.a_y        <= r.ay;
      req_bus.a_z        <= r.az;
      req_bus.b_x        <= r.bx;
      req_bus.b_y        <= r.by;
      req_bus.b_z        <= r.bz;
      req_bus.scalar_in  <= r.scalar;
      req_bus.use_scalar <= r.use_scalar;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      vector_results_q.push_back(typed ? ex : vector_result(r));
      op_count[r.op]++;
   endtask

   task automatic check_field(input string name, input v3alu_pkg::word_type exp,
                              input v3alu_pkg::word_type got);
      if (exp !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, exp, got);
         errors++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Result side: random stalls after each transfer, none while calm.
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready && !calm) begin
         draw = $urandom_range(0, MAX_WAIT);
         rsp_bus.ready <= (draw == 0);
         stall_left <= (draw > 0) ? draw - 1 : 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      vec_rsp_type ex;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (vector_results_q.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h %h %h %h %h", $time,
                     rsp_bus.res_x, rsp_bus.res_y, rsp_bus.res_z, rsp_bus.res_scalar,
                     rsp_bus.status);
            errors++;
         end else begin
            ex = vector_results_q.pop_front();
            check_field("res_x", ex.x, rsp_bus.res_x);
            check_field("res_y", ex.y, rsp_bus.res_y);
            check_field("res_z", ex.z, rsp_bus.res_z);
            check_field("res_scalar", ex.s, rsp_bus.res_scalar);
            check_field("status", 32'(ex.st), 32'(rsp_bus.status));
            status_count[rsp_bus.status]++;
         end
         n_results++;
      end
   end

   initial begin
      vec_rsp_type none;
      req_bus.valid <= 1'b0;
      req_bus.operation <= v3alu_pkg::OP_ADD;
      req_bus.a_x <= '0; req_bus.a_y <= '0; req_bus.a_z <= '0;
      req_bus.b_x <= '0; req_bus.b_y <= '0; req_bus.b_z <= '0;
      req_bus.scalar_in <= '0;
      req_bus.use_scalar <= 1'b0;
      none = '{default: '0};
      stim_table.push_back('{'{v3alu_pkg::OP_ADD, 32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0, 0,
                             1'b0}, 1'b1, '{32'h7fffffff, 0, 0, 0, v3alu_pkg::ST_OVF}});
      stim_table.push_back('{'{v3alu_pkg::OP_SUB, 32'h80000000, 0, 0, 32'h1, 0, 0, 0, 1'b0},
                             1'b1, '{32'h80000000, 0, 0, 0, v3alu_pkg::ST_OVF}});
      stim_table.push_back('{'{v3alu_pkg::OP_DIV, 32'h10000, 0, 0, 0, 0, 0, 0, 1'b0}, 1'b1,
                             '{32'h7fffffff, 0, 0, 0, v3alu_pkg::ST_DIVZERO}});
      stim_table.push_back('{'{v3alu_pkg::OP_DIV, 32'hffff0000, 0, 0, 0, 0, 0, 0, 1'b1}, 1'b1,
                             '{32'h80000000, 0, 0, 0, v3alu_pkg::ST_DIVZERO}});
      stim_table.push_back('{'{v3alu_pkg::OP_ROOT, 32'h10000, 0, 0, 32'hffff0000, 0, 0, 0,
                             1'b0}, 1'b1, '{0, 0, 0, 0, v3alu_pkg::ST_NEGROOT}});
      stim_table.push_back('{'{v3alu_pkg::OP_NORM, 32'h1234, 5, 6, 0, 0, 0, 7, 1'b1}, 1'b1,
                             none});
      stim_table.push_back('{'{OP_SPARE_LO, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                             32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1},
                             1'b1, none});
      stim_table.push_back('{'{v3alu_pkg::OP_LEN, 0, 0, 0, 32'h30000, 32'h40000, 0, 0, 1'b0},
                             1'b1, '{0, 0, 0, 32'h50000, v3alu_pkg::ST_OK}});
      stim_table.push_back('{'{v3alu_pkg::OP_NORM, 0, 0, 0, 32'h30000, 0, 0, 0, 1'b0}, 1'b1,
                             '{32'h10000, 0, 0, 0, v3alu_pkg::ST_OK}});
      stim_table.push_back('{'{OP_SPARE_HI, 1, 2, 3, 4, 5, 6, 7, 1'b0}, 1'b1, none});
      stim_table.push_back('{'{v3alu_pkg::OP_MUL, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                             32'h1, 32'h7fffffff, 32'h80000000, 0, 1'b0}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_MUL, 32'h28000, 32'hfffe0000, 32'h1, 0, 0, 0,
                             32'hfff8000, 1'b1}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_ADD, 32'h80000000, 32'h1, 32'h7fffffff, 0, 0, 0,
                             32'hffffffff, 1'b1}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_SUB, 32'h7fffffff, 32'h80000000, 0, 32'h80000000,
                             32'h7fffffff, 32'h1, 0, 1'b0}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_DIV, 32'h7fffffff, 32'h80000000, 32'h30000,
                             32'h1, 32'h1, 32'hfffe0000, 0, 1'b0}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_DIV, 32'h50000, 32'hfffb0000, 0, 0, 0, 0,
                             32'h20000, 1'b1}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000, 32'h80000000, 0, 1'b0}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_DOT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h80000000, 32'h80000000, 32'h80000000, 0, 1'b1}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_LEN, 0, 0, 0, 32'h80000000, 32'h80000000,
                             32'h80000000, 0, 1'b0}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_ROOT, 32'h7fffffff, 32'h20000, 32'h1,
                             32'h7fffffff, 32'h30000, 32'h1, 0, 1'b0}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_NORM, 0, 0, 0, 32'h80000000, 32'h7fffffff,
                             32'h1, 0, 1'b0}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_NORM, 0, 0, 0, 0, 0, 32'h1, 0, 1'b0}, 1'b0,
                             none});
      stim_table.push_back('{'{v3alu_pkg::OP_SQLEN, 0, 0, 0, 32'h80000000, 32'h80000000,
                             32'h80000000, 0, 1'b0}, 1'b0, none});
      stim_table.push_back('{'{v3alu_pkg::OP_SQLEN, 0, 0, 0, 32'h100, 32'hffffff00, 32'h1, 0,
                             1'b1}, 1'b0, none});

      @(posedge clock);
      while (reset) @(posedge clock);
      foreach (stim_table[i]) send_request(stim_table[i].req, stim_table[i].typed,
                                           stim_table[i].exp);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         // Once midway, hold off until the pipeline has fully drained.
         if (i == RANDOM_ITEMS / 2) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (vector_results_q.size() != 0) @(posedge clock);
         end
         send_request(rand_request(), 1'b0, none);
      end
      req_bus.valid <= 1'b0;
      while (vector_results_q.size() != 0) @(posedge clock);
      repeat (v3alu_pkg::STAGES + 20) @(posedge clock);

      $display("Checked %0d results over %0d directed and %0d random requests.",
               n_results, stim_table.size(), RANDOM_ITEMS);
      $display("Status seen: ok %0d, divide by zero %0d, negative root %0d, overflow %0d.",
               status_count[v3alu_pkg::ST_OK], status_count[v3alu_pkg::ST_DIVZERO],
               status_count[v3alu_pkg::ST_NEGROOT], status_count[v3alu_pkg::ST_OVF]);
      if (errors == 0) begin
         $display("vector3_alu_with_normalize: match");
      end else begin
         $display("vector3_alu_with_normalize: mismatch");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d results still expected.", vector_results_q.size());
      $display("vector3_alu_with_normalize: mismatch");
      $finish;
   end

endmodule
